FILE: rtl/core/lzw_code_table_top_assert.svh
// ----------------------------------------------------------------------------
// LZW code table assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef LZW_CODE_TABLE_TOP_ASSERT_SVH
`define LZW_CODE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LZWCT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzw code table assertion failed");
`define LZWCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzw code table assertion failed");
`else
`define LZWCT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LZWCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/lzwct_pkg.sv
// ----------------------------------------------------------------------------
// LZW code table package
// Shared constants, codes and beat types of the LZW code table.
// ----------------------------------------------------------------------------
package lzwct_pkg;

   localparam int TABLE_DEPTH  = 4096;
   localparam int MAX_CODE_LEN = 64;
   localparam int QUEUE_DEPTH  = 4;

   localparam int IDX_W  = 12;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int CNT_W  = 13;
   localparam int CFG_W  = 13;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;
   localparam int KIND_W = 2;
   localparam int RB_W   = $clog2(MAX_CODE_LEN);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(4096);

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_EXTEND = 2'd1;
   localparam logic [OP_W-1:0] OP_SET    = 2'd2;
   localparam logic [OP_W-1:0] OP_GET    = 2'd3;

   localparam logic [ST_W-1:0] ST_OK         = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL       = 2'd1;
   localparam logic [ST_W-1:0] ST_UNASSIGNED = 2'd2;
   localparam logic [ST_W-1:0] ST_TOO_LONG   = 2'd3;

   localparam logic [KIND_W-1:0] K_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] K_WRITE  = 2'd1;
   localparam logic [KIND_W-1:0] K_SETSUF = 2'd2;
   localparam logic [KIND_W-1:0] K_GET    = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [IDX_W-1:0]  code_index;
      logic [BYTE_W-1:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  new_index;
      logic [BYTE_W-1:0] data_byte;
      logic              last;
      logic [ST_W-1:0]   status;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ST_W-1:0]   status;
      logic [IDX_W-1:0]  code_index;
      logic [IDX_W-1:0]  link;
      logic [BYTE_W-1:0] byte_value;
      logic [LEN_W-1:0]  length;
   } cmd_type;

endpackage

FILE: rtl/core/lzw_code_table_top.sv
// The front end registers each request, classifies it and pushes a command into the queue;
// the back end loads the result register for add, extend, set suffix and errors, and for a
// get walks the code chain, one entry per cycle, then emits one beat per cycle while not
// stalled. The front end takes no new request until the current one is in the queue.
// Reset is synchronous and active high; it empties the table and sets the code limit to 4096.
// ----------------------------------------------------------------------------
// LZW code table top level
// Code dictionary with a classifying front end, a command queue and a back end.
// ----------------------------------------------------------------------------
module lzw_code_table_top
   import lzwct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_write_en,
   input  logic [CFG_W-1:0] csr_write_data
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head;
   logic    q_full;
   logic    q_empty;

   lzwct_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push           (push),
      .push_cmd       (push_cmd),
      .q_full         (q_full)
   );

   lzwct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_full   (q_full),
      .q_empty  (q_empty)
   );

   lzwct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/lzwct_front.sv
// ----------------------------------------------------------------------------
// LZW code table front end
// Accepts request beats, allocates entries and classifies each request.
// ----------------------------------------------------------------------------
module lzwct_front
   import lzwct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  logic             csr_write_en,
   input  logic [CFG_W-1:0] csr_write_data,
   output logic             push,
   output cmd_type          push_cmd,
   input  logic             q_full
);

   localparam logic F_IDLE   = 1'b0;
   localparam logic F_DECIDE = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  codes_used_ff, codes_used_in;
   logic [CFG_W-1:0]  code_limit_ff;
   logic [OP_W-1:0]   op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [LEN_W-1:0]  len_rd_ff;
   logic [LEN_W-1:0]  len_mem [TABLE_DEPTH];

   logic              accept;
   logic              alloc;
   logic              len_we;
   logic [LEN_W-1:0]  new_len;
   logic [CNT_W-1:0]  eff_limit;
   logic              full;
   logic              assigned;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;
   assign eff_limit = (code_limit_ff > CFG_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(code_limit_ff);
   assign full      = (codes_used_ff >= eff_limit);
   assign assigned  = ({1'b0, idx_ff} < codes_used_ff);

   always_comb begin
      push_cmd            = '0;
      push_cmd.kind       = K_STATUS;
      push_cmd.status     = ST_OK;
      push_cmd.code_index = idx_ff;
      alloc               = 1'b0;
      new_len             = LEN_W'(1);
      case (op_ff)
         OP_ADD: begin
            if (full) begin
               push_cmd.status = ST_FULL;
            end else begin
               push_cmd.kind       = K_WRITE;
               push_cmd.code_index = codes_used_ff[IDX_W-1:0];
               push_cmd.byte_value = byte_ff;
               alloc               = 1'b1;
            end
         end
         OP_EXTEND: begin
            if (!assigned) begin
               push_cmd.status = ST_UNASSIGNED;
            end else if (full) begin
               push_cmd.status = ST_FULL;
            end else if (len_rd_ff >= LEN_W'(MAX_CODE_LEN)) begin
               push_cmd.status = ST_TOO_LONG;
            end else begin
               push_cmd.kind       = K_WRITE;
               push_cmd.code_index = codes_used_ff[IDX_W-1:0];
               push_cmd.link       = idx_ff;
               alloc               = 1'b1;
               new_len             = len_rd_ff + LEN_W'(1);
            end
         end
         OP_SET: begin
            if (!assigned) begin
               push_cmd.status = ST_UNASSIGNED;
            end else begin
               push_cmd.kind       = K_SETSUF;
               push_cmd.byte_value = byte_ff;
            end
         end
         OP_GET: begin
            if (!assigned) begin
               push_cmd.status = ST_UNASSIGNED;
            end else begin
               push_cmd.kind   = K_GET;
               push_cmd.length = (len_rd_ff == '0) ? LEN_W'(1) : len_rd_ff;
            end
         end
         default: begin
            push_cmd.status = ST_UNASSIGNED;
         end
      endcase
   end

   assign push          = (state_ff == F_DECIDE) && !q_full;
   assign len_we        = push && alloc;
   assign codes_used_in = len_we ? codes_used_ff + CNT_W'(1) : codes_used_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_DECIDE;
            end
         end
         F_DECIDE: begin
            if (push) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         codes_used_ff <= '0;
         code_limit_ff <= LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         codes_used_ff <= codes_used_in;
         if (csr_write_en) begin
            code_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.operation;
         idx_ff    <= req_data.code_index;
         byte_ff   <= req_data.byte_value;
         len_rd_ff <= len_mem[req_data.code_index];
      end
      if (len_we) begin
         len_mem[codes_used_ff[IDX_W-1:0]] <= new_len;
      end
   end

endmodule

FILE: rtl/core/lzwct_queue.sv
// ----------------------------------------------------------------------------
// LZW code table command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module lzwct_queue
   import lzwct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    q_full,
   output logic    q_empty
);

   cmd_type           q_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign q_full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign head    = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/lzwct_back.sv
// ----------------------------------------------------------------------------
// LZW code table back end
// Holds the prefix and suffix stores, walks code chains and drives results.
// ----------------------------------------------------------------------------
`include "lzw_code_table_top_assert.svh"

module lzwct_back
   import lzwct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head,
   input  logic    q_empty,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_WALK = 2'd1;
   localparam logic [1:0] B_EMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [RB_W-1:0]   k_ff, k_in;
   logic [IDX_W-1:0]  pre_rd_ff;
   logic [BYTE_W-1:0] suf_rd_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  prefix_mem [TABLE_DEPTH];
   logic [BYTE_W-1:0] suffix_mem [TABLE_DEPTH];
   logic [BYTE_W-1:0] rev_mem [MAX_CODE_LEN];

   logic              load_ok;
   logic              rsp_load;
   logic              emit;
   logic              wr_entry;
   logic              wr_suf;
   logic              rev_we;
   logic [RB_W-1:0]   rev_wa;
   logic [IDX_W-1:0]  rd_addr;

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign rd_addr   = (state_ff == B_WALK) ? pre_rd_ff : head.code_index;
   assign rev_wa    = RB_W'(cnt_ff - LEN_W'(1));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in         = state_ff;
      len_in           = len_ff;
      cnt_in           = cnt_ff;
      k_in             = k_ff;
      pop              = 1'b0;
      rsp_load         = 1'b0;
      emit             = 1'b0;
      wr_entry         = 1'b0;
      wr_suf           = 1'b0;
      rev_we           = 1'b0;
      rsp_in           = '0;
      rsp_in.last      = 1'b1;
      rsp_in.status    = head.status;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (head.kind == K_GET) begin
                  pop      = 1'b1;
                  len_in   = head.length;
                  cnt_in   = head.length;
                  state_in = B_WALK;
               end else if (load_ok) begin
                  pop      = 1'b1;
                  rsp_load = 1'b1;
                  case (head.kind)
                     K_WRITE: begin
                        wr_entry         = 1'b1;
                        rsp_in.new_index = head.code_index;
                     end
                     K_SETSUF: begin
                        wr_suf = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         B_WALK: begin
            rev_we = 1'b1;
            cnt_in = cnt_ff - LEN_W'(1);
            if (cnt_ff == LEN_W'(1)) begin
               k_in     = '0;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            rsp_in.status = ST_OK;
            rsp_in.last   = ((LEN_W'(k_ff) + LEN_W'(1)) == len_ff);
            if (load_ok) begin
               rsp_load = 1'b1;
               emit     = 1'b1;
               k_in     = k_ff + RB_W'(1);
               if (rsp_in.last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      pre_rd_ff <= prefix_mem[rd_addr];
      suf_rd_ff <= suffix_mem[rd_addr];
      if (wr_entry) begin
         prefix_mem[head.code_index] <= head.link;
         suffix_mem[head.code_index] <= head.byte_value;
      end else if (wr_suf) begin
         suffix_mem[head.code_index] <= head.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[rev_wa] <= suf_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.new_index <= rsp_in.new_index;
         rsp_ff.data_byte <= emit ? rev_mem[k_ff] : rsp_in.data_byte;
         rsp_ff.last      <= rsp_in.last;
         rsp_ff.status    <= rsp_in.status;
      end
   end

   `LZWCT_ASSERT_IMPLY(a_walk_count, clock, reset, state_ff == B_WALK, cnt_ff != '0)
   `LZWCT_ASSERT_IMPLY(a_emit_bound, clock, reset, state_ff == B_EMIT, LEN_W'(k_ff) < len_ff)
   `LZWCT_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, !q_empty)
   `LZWCT_ASSERT_NEXT(a_emit_done, clock, reset, emit && rsp_in.last, state_ff == B_IDLE && rsp_valid_ff && rsp_ff.last)

endmodule

FILE: tb/tb_lzw_code_table_top.sv
// ----------------------------------------------------------------------------
// LZW code table testbench
// Drives add, extend, set suffix and get requests into the code table under
// several code limits, with random gaps on the request side and random stalls
// on the response side. A scoreboard class keeps its own copy of the table,
// predicts every response beat and checks each one field by field, in order.
// ----------------------------------------------------------------------------
module tb_lzw_code_table_top;
   import lzwct_pkg::*;

   class lzw_table_scoreboard;
      logic [IDX_W-1:0]  link_mem [TABLE_DEPTH];
      logic [BYTE_W-1:0] tail_mem [TABLE_DEPTH];
      logic [LEN_W-1:0]  len_mem [TABLE_DEPTH];
      int unsigned       used;
      int unsigned       limit;
      int                errors;
      rsp_type           expected_q[$];

      function new();
         used   = 0;
         limit  = TABLE_DEPTH;
         errors = 0;
      endfunction

      function void write_limit(logic [CFG_W-1:0] value);
         limit = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void queue_result(int unsigned index, logic [BYTE_W-1:0] data, bit last,
                                 logic [ST_W-1:0] status);
         rsp_type beat;
         beat.new_index = index[IDX_W-1:0];
         beat.data_byte = data;
         beat.last      = last;
         beat.status    = status;
         expected_q.push_back(beat);
      endfunction

      function void note_request(req_type req);
         int unsigned       effective;
         int unsigned       idx;
         int unsigned       count;
         int unsigned       entry;
         bit                full;
         bit                assigned;
         logic [BYTE_W-1:0] bytes [MAX_CODE_LEN];
         effective = (limit > TABLE_DEPTH) ? TABLE_DEPTH : limit;
         idx       = req.code_index;
         full      = (used >= effective);
         assigned  = (idx < used);
         case (req.operation)
            OP_ADD: begin
               if (full) begin
                  queue_result(0, '0, 1'b1, ST_FULL);
               end else begin
                  link_mem[used] = '0;
                  tail_mem[used] = req.byte_value;
                  len_mem[used]  = LEN_W'(1);
                  queue_result(used, '0, 1'b1, ST_OK);
                  used++;
               end
            end
            OP_EXTEND: begin
               if (!assigned) begin
                  queue_result(0, '0, 1'b1, ST_UNASSIGNED);
               end else if (full) begin
                  queue_result(0, '0, 1'b1, ST_FULL);
               end else if (len_mem[idx] + 1 > MAX_CODE_LEN) begin
                  queue_result(0, '0, 1'b1, ST_TOO_LONG);
               end else begin
                  link_mem[used] = idx[IDX_W-1:0];
                  tail_mem[used] = '0;
                  len_mem[used]  = len_mem[idx] + LEN_W'(1);
                  queue_result(used, '0, 1'b1, ST_OK);
                  used++;
               end
            end
            OP_SET: begin
               if (!assigned) begin
                  queue_result(0, '0, 1'b1, ST_UNASSIGNED);
               end else begin
                  tail_mem[idx] = req.byte_value;
                  queue_result(0, '0, 1'b1, ST_OK);
               end
            end
            default: begin
               if (!assigned) begin
                  queue_result(0, '0, 1'b1, ST_UNASSIGNED);
               end else begin
                  count = len_mem[idx];
                  if (count > MAX_CODE_LEN) count = MAX_CODE_LEN;
                  if (count == 0) count = 1;
                  entry = idx;
                  for (int i = count; i > 0; i--) begin
                     bytes[i-1] = tail_mem[entry];
                     entry = link_mem[entry];
                  end
                  for (int i = 0; i < count; i++) begin
                     queue_result(0, bytes[i], (i + 1 == count), ST_OK);
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: beat expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("new_index", want.new_index, got.new_index);
         compare_field("data_byte", want.data_byte, got.data_byte);
         compare_field("last", want.last, got.last);
         compare_field("status", want.status, got.status);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write_en = 1'b0;
   logic [CFG_W-1:0] csr_write_data = '0;

   lzw_table_scoreboard sb = new();
   bit                  steady = 1'b0;
   int unsigned         chain_tip = 0;

   lzw_code_table_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 33);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   task automatic send_request(req_type beat);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      sb.note_request(beat);
   endtask

   task automatic send_op(logic [OP_W-1:0] op, int unsigned idx, logic [BYTE_W-1:0] data);
      req_type beat;
      beat.operation  = op;
      beat.code_index = idx[IDX_W-1:0];
      beat.byte_value = data;
      send_request(beat);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [CFG_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_limit(value);
      @(posedge clock);
   endtask

   function automatic int unsigned pick_assigned();
      if ($urandom_range(0, 1)) return chain_tip;
      return $urandom_range(0, sb.used - 1);
   endfunction

   task automatic random_op();
      int          pick;
      int unsigned used_before;
      bit          tip_extend;
      pick        = $urandom_range(0, 99);
      used_before = sb.used;
      tip_extend  = 1'b0;
      if (sb.used == 0 || pick < 12) begin
         send_op(OP_ADD, $urandom_range(0, TABLE_DEPTH - 1), BYTE_W'($urandom_range(0, 255)));
         if (sb.used != used_before && sb.len_mem[chain_tip] == MAX_CODE_LEN) begin
            chain_tip = sb.used - 1;
         end
      end else if (pick < 50) begin
         tip_extend = 1'b1;
         send_op(OP_EXTEND, chain_tip, BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 60) begin
         send_op(OP_EXTEND, $urandom_range(0, sb.used - 1), BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 72) begin
         send_op(OP_SET, pick_assigned(), BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 88) begin
         send_op(OP_GET, pick_assigned(), BYTE_W'($urandom_range(0, 255)));
      end else begin
         send_op(OP_W'($urandom_range(0, 3)),
                 $urandom_range(0, 1) ? sb.used : $urandom_range(0, TABLE_DEPTH - 1),
                 BYTE_W'($urandom_range(0, 255)));
      end
      if (tip_extend && sb.used != used_before) begin
         chain_tip = sb.used - 1;
         if ($urandom_range(0, 1)) begin
            send_op(OP_SET, chain_tip, BYTE_W'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_op(OP_GET, 0, 8'h00);
      send_op(OP_EXTEND, 0, 8'h00);
      send_op(OP_SET, 0, 8'hFF);
      send_op(OP_ADD, 4095, 8'h00);
      send_op(OP_ADD, 0, 8'hFF);
      send_op(OP_ADD, 2048, 8'hA5);
      send_op(OP_GET, 0, 8'h00);
      send_op(OP_GET, 1, 8'h00);
      send_op(OP_EXTEND, 1, 8'hFF);
      send_op(OP_EXTEND, 3, 8'h00);
      send_op(OP_SET, 4, 8'hFF);
      send_op(OP_SET, 3, 8'h5A);
      send_op(OP_GET, 4, 8'h00);
      send_op(OP_GET, 4095, 8'hFF);
      send_op(OP_EXTEND, 4095, 8'hFF);
      send_op(OP_SET, 4095, 8'hFF);
      send_op(OP_GET, sb.used, 8'h00);
      send_op(OP_EXTEND, sb.used, 8'h00);
      drain();

      write_limit('0);
      send_op(OP_ADD, 0, 8'h3C);
      send_op(OP_EXTEND, 4, 8'h00);
      send_op(OP_EXTEND, 4095, 8'h00);
      send_op(OP_SET, 0, 8'hC3);
      send_op(OP_GET, 4, 8'h00);
      drain();
      chain_tip = 4;

      write_limit({CFG_W{1'b1}});
      for (int i = 0; i < 160; i++) begin
         steady = (i >= 50 && i < 110);
         random_op();
      end
      steady = 1'b0;
      drain();

      write_limit(CFG_W'(sb.used + 5));
      repeat (70) random_op();
      drain();

      write_limit(CFG_W'(TABLE_DEPTH));
      repeat (70) random_op();
      drain();

      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #50000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: lzw_code_table_top.f
+incdir+rtl/core
rtl/core/lzwct_pkg.sv
rtl/core/lzwct_front.sv
rtl/core/lzwct_queue.sv
rtl/core/lzwct_back.sv
rtl/core/lzw_code_table_top.sv
tb/tb_lzw_code_table_top.sv
